// ===== rtl/otc_pkg.sv =====
package otc_pkg;

    // Histogram counter width and the top bin, which collects all larger counts.
    localparam int HIST_COUNT_WIDTH = 20;
    localparam int TOP_BIN          = 5;
    localparam int NUM_BINS         = TOP_BIN + 1;
    localparam int BIN_W            = $clog2(NUM_BINS);

    // Fixed field widths of the stream items.
    localparam int TLEN_W      = 5;
    localparam int BLEN_W      = 12;
    localparam int MATCH_W     = 12;
    localparam int BIN_OUT_W   = 3;
    localparam int HIST_OUT_W  = 20;
    localparam int NUM_HIST_OUT = 6;
    localparam int OUT_DATA_W  = 136;
    localparam int IN_DATA_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Reset values of the configuration registers.
    localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(9);
    localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(1032);

    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;
    localparam logic [HIST_COUNT_WIDTH-1:0] HIST_MAX = '1;

    // Depth of the queue between the bit front end and the histogram back end.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TEMPLATE_LENGTH = 2'd0,
        CFG_BLOCK_LENGTH    = 2'd1
    } cfg_index_t;

    // One finished block as handed from the front end to the back end.
    typedef struct packed {
        logic               clear_hist;
        logic [MATCH_W-1:0] match_count;
    } blk_rec_t;

    typedef logic [HIST_COUNT_WIDTH-1:0] hist_cnt_t;
    typedef logic [HIST_OUT_W-1:0]       hist_out_t;

endpackage

// ===== rtl/otc_front.sv =====
module otc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    input  logic [otc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [otc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // One accepted bit.
    input  logic                               bit_accept,
    input  logic                               seq_bit,
    input  logic                               start_sequence,
    // Finished block toward the queue.
    output logic                               rec_push,
    output otc_pkg::blk_rec_t                  rec
);

    logic [otc_pkg::TLEN_W-1:0]  tlen_reg;
    logic [otc_pkg::BLEN_W-1:0]  blen_reg;
    logic [otc_pkg::BLEN_W-1:0]  pos_reg, pos_next;
    logic [otc_pkg::TLEN_W-1:0]  run_reg, run_next;
    logic [otc_pkg::MATCH_W-1:0] cnt_reg, cnt_next;
    logic                        clr_reg, clr_next;

    logic [otc_pkg::TLEN_W-1:0]  m_len;
    logic [otc_pkg::BLEN_W-1:0]  last_pos;
    logic [otc_pkg::BLEN_W-1:0]  pos_eff;
    logic [otc_pkg::TLEN_W-1:0]  run_eff;
    logic [otc_pkg::MATCH_W-1:0] cnt_eff;
    logic                        clr_eff;
    logic                        blk_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg <= otc_pkg::TLEN_RESET;
            blen_reg <= otc_pkg::BLEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (otc_pkg::cfg_index_t'(cfg_index))
                otc_pkg::CFG_TEMPLATE_LENGTH: tlen_reg <= cfg_data[otc_pkg::TLEN_W-1:0];
                otc_pkg::CFG_BLOCK_LENGTH:    blen_reg <= cfg_data[otc_pkg::BLEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Run-length and match counting for the incoming bit.
    always_comb
    begin
        m_len    = (tlen_reg == '0) ? otc_pkg::TLEN_W'(1) : tlen_reg;
        last_pos = blen_reg - otc_pkg::BLEN_W'(1);
        pos_eff  = start_sequence ? '0 : pos_reg;
        clr_eff  = start_sequence | clr_reg;
        run_eff  = (pos_eff == '0) ? '0 : run_reg;
        cnt_eff  = (pos_eff == '0) ? '0 : cnt_reg;

        run_next = '0;
        cnt_next = cnt_eff;
        if (seq_bit)
        begin
            run_next = (run_eff < m_len) ? run_eff + otc_pkg::TLEN_W'(1) : run_eff;
            if (run_next >= m_len && cnt_eff != otc_pkg::MATCH_MAX)
            begin
                cnt_next = cnt_eff + otc_pkg::MATCH_W'(1);
            end
        end

        blk_end  = (pos_eff == last_pos);
        pos_next = blk_end ? '0 : pos_eff + otc_pkg::BLEN_W'(1);
        // A pending histogram clear rides along with the next finished block.
        clr_next = blk_end ? 1'b0 : clr_eff;

        rec_push             = bit_accept & blk_end;
        rec.clear_hist       = clr_eff;
        rec.match_count      = cnt_next;
    end

    // Block state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            run_reg <= '0;
            cnt_reg <= '0;
            clr_reg <= 1'b0;
        end
        else if (bit_accept)
        begin
            pos_reg <= pos_next;
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

endmodule

// ===== rtl/otc_fifo.sv =====
module otc_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  otc_pkg::blk_rec_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output otc_pkg::blk_rec_t pop_data
);

    otc_pkg::blk_rec_t mem [otc_pkg::FIFO_DEPTH];

    logic [otc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [otc_pkg::FIFO_CNT_W-1:0] count_reg;

    assign full      = (count_reg == otc_pkg::FIFO_CNT_W'(otc_pkg::FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == otc_pkg::FIFO_PTR_W'(otc_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + otc_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == otc_pkg::FIFO_PTR_W'(otc_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + otc_pkg::FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + otc_pkg::FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - otc_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    // A block record must never be written into a full queue or read from an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("block record pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !pop_valid))
        else $error("block record popped from an empty queue");

endmodule

// ===== rtl/otc_back.sv =====
module otc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rec_valid,
    input  otc_pkg::blk_rec_t                   rec,
    output logic                                rec_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [otc_pkg::MATCH_W-1:0]         out_matches,
    output logic [otc_pkg::BIN_OUT_W-1:0]       out_bin,
    output otc_pkg::hist_out_t                  out_hist [otc_pkg::NUM_HIST_OUT]
);

    otc_pkg::hist_cnt_t hist_reg  [otc_pkg::NUM_BINS];
    otc_pkg::hist_cnt_t hist_next [otc_pkg::NUM_BINS];
    otc_pkg::hist_out_t ohist_reg [otc_pkg::NUM_HIST_OUT];
    otc_pkg::hist_out_t ohist_next[otc_pkg::NUM_HIST_OUT];

    logic                          ovalid_reg;
    logic [otc_pkg::MATCH_W-1:0]   omatch_reg;
    logic [otc_pkg::BIN_OUT_W-1:0] obin_reg;
    logic [otc_pkg::BIN_W-1:0]     bin;
    logic                          load;

    // Take a record when the output register is empty or is being emptied.
    assign load    = rec_valid & (~ovalid_reg | out_ready);
    assign rec_pop = load;

    // Bin selection and saturating histogram update.
    always_comb
    begin
        bin = (rec.match_count < otc_pkg::MATCH_W'(otc_pkg::TOP_BIN))
              ? rec.match_count[otc_pkg::BIN_W-1:0]
              : otc_pkg::BIN_W'(otc_pkg::TOP_BIN);
        for (int b = 0; b < otc_pkg::NUM_BINS; b++)
        begin
            hist_next[b] = rec.clear_hist ? '0 : hist_reg[b];
            if (bin == otc_pkg::BIN_W'(b) && hist_next[b] != otc_pkg::HIST_MAX)
            begin
                hist_next[b] = hist_next[b] + otc_pkg::HIST_COUNT_WIDTH'(1);
            end
        end
        for (int j = 0; j < otc_pkg::NUM_HIST_OUT; j++)
        begin
            ohist_next[j] = '0;
            if (j < otc_pkg::NUM_BINS)
            begin
                ohist_next[j] = otc_pkg::HIST_OUT_W'(hist_next[j]);
            end
        end
    end

    // Histogram counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < otc_pkg::NUM_BINS; b++)
            begin
                hist_reg[b] <= '0;
            end
        end
        else if (load)
        begin
            for (int b = 0; b < otc_pkg::NUM_BINS; b++)
            begin
                hist_reg[b] <= hist_next[b];
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            omatch_reg <= rec.match_count;
            obin_reg   <= otc_pkg::BIN_OUT_W'(bin);
            for (int j = 0; j < otc_pkg::NUM_HIST_OUT; j++)
            begin
                ohist_reg[j] <= ohist_next[j];
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_matches = omatch_reg;
    assign out_bin     = obin_reg;
    always_comb
    begin
        for (int j = 0; j < otc_pkg::NUM_HIST_OUT; j++)
        begin
            out_hist[j] = ohist_reg[j];
        end
    end

    // A loaded record always shows up as a valid result in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n) load |=> out_valid)
        else $error("loaded block result not presented");
    // A result that is still waiting must not be overwritten by a new record.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
                                     (out_valid && !out_ready) |-> !rec_pop)
        else $error("pending block result overwritten");

endmodule

// ===== rtl/overlapping_ones_template_counter.sv =====
// Overlapping all-ones template counter: takes one sequence bit per transaction, cuts the
// stream into blocks of block_length bits and counts the overlapping windows of
// template_length consecutive ones inside each block. At every block end it emits one
// transaction with the block's match count, its bin (0 to 4, or 5 for five and more) and
// the six saturating histogram counters including that block; other bits emit nothing.
// A bit with start_sequence set clears the histogram and the block position first.
// The block takes one bit every clock cycle; a finished block reaches the output
// through a two-entry block queue and the output register. Input stalls only when that
// queue is full because results are not being taken.
// Configuration is written through the cfg channel (index 0 template_length, index 1
// block_length). Users must write it only while the block is idle; it is not enforced.
module overlapping_ones_template_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input bit stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [otc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [0] seq_bit, rest zero
    input  logic                                s_axis_tuser,  // [0] start_sequence
    // Per-block results.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] block_matches, [14:12] bin_index, [34:15] hist_zero, [54:35] hist_one,
    // [74:55] hist_two, [94:75] hist_three, [114:95] hist_four, [134:115] hist_many,
    // [135] zero
    output logic [otc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [otc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [otc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                          bit_accept;
    logic                          rec_push;
    logic                          rec_pop;
    logic                          fifo_full;
    logic                          rec_valid;
    otc_pkg::blk_rec_t             push_rec;
    otc_pkg::blk_rec_t             pop_rec;
    logic [otc_pkg::MATCH_W-1:0]   out_matches;
    logic [otc_pkg::BIN_OUT_W-1:0] out_bin;
    otc_pkg::hist_out_t            out_hist [otc_pkg::NUM_HIST_OUT];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ~fifo_full;
    assign bit_accept    = s_axis_tvalid & s_axis_tready;

    // Front end: block position, run of ones and match count.
    otc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .bit_accept     (bit_accept),
        .seq_bit        (s_axis_tdata[0]),
        .start_sequence (s_axis_tuser),
        .rec_push       (rec_push),
        .rec            (push_rec)
    );

    // Queue of finished blocks.
    otc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (fifo_full),
        .pop       (rec_pop),
        .pop_valid (rec_valid),
        .pop_data  (pop_rec)
    );

    // Back end: histogram and result register.
    otc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (rec_valid),
        .rec         (pop_rec),
        .rec_pop     (rec_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_matches (out_matches),
        .out_bin     (out_bin),
        .out_hist    (out_hist)
    );

    // Result packing, first field in the lowest bits.
    assign m_axis_tdata = {1'b0, out_hist[5], out_hist[4], out_hist[3], out_hist[2],
                           out_hist[1], out_hist[0], out_bin, out_matches};

endmodule
